// ===== hw/rtl/tvps_pkg.sv =====
// Shared types and constants for the tree vertical path splitter.
`timescale 1ns / 1ps

package tvps_pkg;

  // Width of a node id, a path length and a path count on the ports
  localparam int ID_W = 6;
  // Node count carried between front and back; holds counts up to 127
  localparam int CNT_W = 7;
  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  // One classified request handed from the front to the back
  typedef struct packed {
    logic [ID_W-1:0]  parent;  // one-based parent of this node
    logic             last;    // final node of the tree
    logic             store;   // node fits in the table
    logic [CNT_W-1:0] cnt;     // nodes held after this request
  } tvps_item_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    B_LOAD,
    B_SINGLE,
    B_COUNT,
    B_SCAN,
    B_CLIMB_RD,
    B_CLIMB_CHK,
    B_EMIT_RD,
    B_EMIT_PUT,
    B_DONE
  } tvps_state_t;

endpackage

// ===== hw/rtl/tree_vertical_path_splitter.sv =====
// Top level of the tree vertical path splitter.
`timescale 1ns / 1ps

// Loads a rooted tree one parent per request (one-based, the root names
// itself) and, after the request marked tlast, splits it into vertical paths:
// from each leaf in index order it climbs through unused nodes, then emits
// every node path by path, top first, with path length, path total and a
// first-node flag; tlast marks the final result. Loading takes one request
// per cycle into a four-entry queue while the queue is not full. After the
// last node the run counts leaves, then scans for leaves, climbs and emits
// through the single read port of the parent table and of the path buffer.
// Requests beyond MAX_NODES are dropped, but their tlast still starts
// the run.
module tree_vertical_path_splitter #(
  parameter int MAX_NODES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] parent_index, [7:6] zero
  input  logic        s_axis_tlast,   // last_node
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] node_id, [11:6] path_length,
                                      // [17:12] path_total, [23:18] zero
  output logic        m_axis_tuser,   // path_first
  output logic        m_axis_tlast    // last_result
);
  import tvps_pkg::*;

  logic            push, full, pop, empty;
  tvps_item_t      push_data, pop_data;
  logic [ID_W-1:0] out_node, out_len, out_total;

  tvps_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_parent (s_axis_tdata[ID_W-1:0]),
    .in_last   (s_axis_tlast),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  tvps_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  tvps_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (pop_data),
    .empty     (empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_node  (out_node),
    .out_len   (out_len),
    .out_total (out_total),
    .out_first (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, out_total, out_len, out_node};

`ifndef SYNTH
  // Front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("request pushed into full queue");

  // Back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("request popped from empty queue");

  // A final result that also opens a path belongs to a one-node path
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast && m_axis_tuser) |-> (m_axis_tdata[11:6] == 6'd1))
    else $error("final path start with length other than one");
`endif

endmodule

// ===== hw/rtl/tvps_fifo.sv =====
// Short request queue between the front and back of the path splitter.
`timescale 1ns / 1ps

module tvps_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tvps_pkg::tvps_item_t push_data,
  output logic                full,
  input  logic                pop,
  output tvps_pkg::tvps_item_t pop_data,
  output logic                empty
);
  import tvps_pkg::*;

  tvps_item_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign full     = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/tvps_front.sv =====
// Front end: accepts parent requests, counts nodes and marks overflow drops.
`timescale 1ns / 1ps

module tvps_front #(
  parameter int MAX_NODES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tvps_pkg::ID_W-1:0]  in_parent,
  input  logic                       in_last,
  output logic                       push,
  output tvps_pkg::tvps_item_t       push_data,
  input  logic                       full
);
  import tvps_pkg::*;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_NODES);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             store;
  logic             take;

  assign in_ready = !full;
  assign take     = in_valid && !full;

  // Classify: keep the node while capacity remains, otherwise drop it
  always_comb begin
    store    = (cnt < CAP);
    cnt_next = store ? cnt + 1'b1 : cnt;
    push     = take;
    push_data.parent = in_parent;
    push_data.last   = in_last;
    push_data.store  = store;
    push_data.cnt    = cnt_next;
  end

  // Count nodes of the current tree; restart after its last node
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (take) begin
      cnt <= in_last ? '0 : cnt_next;
    end
  end

endmodule

// ===== hw/rtl/tvps_back.sv =====
// Back end: builds the parent table, splits the tree into paths and emits them.
`timescale 1ns / 1ps

module tvps_back #(
  parameter int MAX_NODES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tvps_pkg::tvps_item_t       item,
  input  logic                       empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tvps_pkg::ID_W-1:0]  out_node,
  output logic [tvps_pkg::ID_W-1:0]  out_len,
  output logic [tvps_pkg::ID_W-1:0]  out_total,
  output logic                       out_first,
  output logic                       out_last
);
  import tvps_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  tvps_state_t state, state_next;

  logic [CW-1:0] n, n_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] total, total_next;
  logic [CW-1:0] path_no, path_no_next;
  logic [CW-1:0] len, len_next;
  logic [CW-1:0] j, j_next;
  logic [IW-1:0] v, v_next;

  logic [MAX_NODES-1:0] has_child;
  logic [MAX_NODES-1:0] used;

  logic [ID_W-1:0] parent_mem [MAX_NODES];
  logic [ID_W-1:0] path_mem [MAX_NODES];
  logic [ID_W-1:0] pmem_q;
  logic [ID_W-1:0] pbuf_q;

  logic            pm_we, pm_re, pb_we, pb_re;
  logic [IW-1:0]   pm_waddr, pm_raddr, pb_waddr, pb_raddr;
  logic [ID_W-1:0] pm_wdata, pb_wdata;
  logic            hc_set, used_set, clear_marks;
  logic [IW-1:0]   hc_idx, used_idx;

  logic            out_free, out_load;
  logic [ID_W-1:0] ld_node, ld_len, ld_total;
  logic            ld_first, ld_last;

  logic [IW-1:0]   i_idx;
  logic [IW-1:0]   q_idx;
  logic            climb_stop;

  assign out_free = !out_valid || out_ready;
  assign i_idx    = IW'(i);
  assign q_idx    = IW'(pmem_q - 1'b1);

  // Climb ends at an invalid parent, the root or a node already on a path
  assign climb_stop = (pmem_q == '0) || (CNT_W'(pmem_q) > CNT_W'(n)) ||
                      (q_idx == v) || used[q_idx];

  // State register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_LOAD;
      n       <= '0;
      i       <= '0;
      total   <= '0;
      path_no <= '0;
      len     <= '0;
      j       <= '0;
      v       <= '0;
    end else begin
      state   <= state_next;
      n       <= n_next;
      i       <= i_next;
      total   <= total_next;
      path_no <= path_no_next;
      len     <= len_next;
      j       <= j_next;
      v       <= v_next;
    end
  end

  // Sequence loading, leaf counting, climbing and emission
  always_comb begin
    state_next   = state;
    n_next       = n;
    i_next       = i;
    total_next   = total;
    path_no_next = path_no;
    len_next     = len;
    j_next       = j;
    v_next       = v;
    pop          = 1'b0;
    pm_we        = 1'b0;
    pm_waddr     = IW'(item.cnt - 1'b1);
    pm_wdata     = item.parent;
    pm_re        = 1'b0;
    pm_raddr     = v;
    pb_we        = 1'b0;
    pb_waddr     = IW'(len);
    pb_wdata     = pmem_q;
    pb_re        = 1'b0;
    pb_raddr     = IW'(j - 1'b1);
    hc_set       = 1'b0;
    hc_idx       = IW'(item.parent - 1'b1);
    used_set     = 1'b0;
    used_idx     = q_idx;
    clear_marks  = 1'b0;
    out_load     = 1'b0;
    ld_node      = pbuf_q;
    ld_len       = ID_W'(len);
    ld_total     = ID_W'(total);
    ld_first     = (j == len);
    ld_last      = (path_no == total) && (j == CW'(1));

    case (state)
      B_LOAD: begin
        if (!empty) begin
          pop = 1'b1;
          if (item.store) begin
            pm_we = 1'b1;
            if ((item.parent != '0) &&
                (CNT_W'(item.parent) <= CNT_W'(MAX_NODES))) begin
              hc_set = 1'b1;
            end
          end
          if (item.last) begin
            n_next = CW'(item.cnt);
            if (item.cnt == CNT_W'(1)) begin
              state_next = B_SINGLE;
            end else begin
              i_next     = '0;
              total_next = '0;
              state_next = B_COUNT;
            end
          end
        end
      end

      B_SINGLE: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_node    = ID_W'(1);
          ld_len     = ID_W'(1);
          ld_total   = ID_W'(1);
          ld_first   = 1'b1;
          ld_last    = 1'b1;
          state_next = B_DONE;
        end
      end

      // Count leaves: the path total goes out with every result
      B_COUNT: begin
        if (i == n) begin
          i_next       = '0;
          path_no_next = '0;
          state_next   = B_SCAN;
        end else begin
          if (!has_child[i_idx]) begin
            total_next = total + 1'b1;
          end
          i_next = i + 1'b1;
        end
      end

      // Find the next leaf and open a path at it
      B_SCAN: begin
        if (i == n) begin
          state_next = B_DONE;
        end else if (!has_child[i_idx]) begin
          v_next       = i_idx;
          used_set     = 1'b1;
          used_idx     = i_idx;
          pb_we        = 1'b1;
          pb_waddr     = '0;
          pb_wdata     = ID_W'(CNT_W'(i_idx) + 1'b1);
          len_next     = CW'(1);
          path_no_next = path_no + 1'b1;
          state_next   = B_CLIMB_RD;
        end else begin
          i_next = i + 1'b1;
        end
      end

      B_CLIMB_RD: begin
        pm_re      = 1'b1;
        state_next = B_CLIMB_CHK;
      end

      // Step to the parent or close the path
      B_CLIMB_CHK: begin
        if (climb_stop) begin
          j_next     = len;
          state_next = B_EMIT_RD;
        end else begin
          v_next     = q_idx;
          used_set   = 1'b1;
          pb_we      = 1'b1;
          len_next   = len + 1'b1;
          state_next = B_CLIMB_RD;
        end
      end

      B_EMIT_RD: begin
        pb_re      = 1'b1;
        state_next = B_EMIT_PUT;
      end

      // Emit the path top first, i.e. in reverse of the climb
      B_EMIT_PUT: begin
        if (out_free) begin
          out_load = 1'b1;
          j_next   = j - 1'b1;
          if (j == CW'(1)) begin
            i_next     = i + 1'b1;
            state_next = B_SCAN;
          end else begin
            state_next = B_EMIT_RD;
          end
        end
      end

      B_DONE: begin
        clear_marks = 1'b1;
        state_next  = B_LOAD;
      end

      default: begin
        state_next = B_LOAD;
      end
    endcase
  end

  // Child and used marks; drop both once a tree is finished
  always_ff @(posedge clk) begin
    if (rst) begin
      has_child <= '0;
      used      <= '0;
    end else if (clear_marks) begin
      has_child <= '0;
      used      <= '0;
    end else begin
      if (hc_set) begin
        has_child[hc_idx] <= 1'b1;
      end
      if (used_set) begin
        used[used_idx] <= 1'b1;
      end
    end
  end

  // Parent table
  always_ff @(posedge clk) begin
    if (pm_we) begin
      parent_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pmem_q <= parent_mem[pm_raddr];
    end
  end

  // Path buffer
  always_ff @(posedge clk) begin
    if (pb_we) begin
      path_mem[pb_waddr] <= pb_wdata;
    end
    if (pb_re) begin
      pbuf_q <= path_mem[pb_raddr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_node  <= ld_node;
      out_len   <= ld_len;
      out_total <= ld_total;
      out_first <= ld_first;
      out_last  <= ld_last;
    end
  end

endmodule
